// ----- design/ssd_pkg.sv -----
// Shared types, codes and constants for the seven-segment scan driver.
`default_nettype none
package ssd_pkg;

  // Number of digit positions driven by the scan.
  localparam int DIGITS = 4;

  // Expander frame bytes.
  localparam logic [7:0] OP_WRITE  = 8'h40;
  localparam logic [7:0] REG_DIRA  = 8'h00;
  localparam logic [7:0] REG_LATA  = 8'h14;
  localparam logic [7:0] DIR_A_VAL = 8'hF0;
  localparam logic [7:0] DIR_B_VAL = 8'h00;

  localparam logic [7:0] SEG_TABLE [16] = '{
    8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0,
    8'hFE, 8'hF6, 8'hEE, 8'h3E, 8'h9C, 8'h7A, 8'h9E, 8'h8E
  };

  typedef enum logic [1:0] {
    MODE_INIT = 2'd0,
    MODE_LOAD = 2'd1,
    MODE_SCAN = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  // Item after the thousands split.
  typedef struct packed {
    mode_t      mode;
    logic [6:0] d3;
    logic [9:0] rem;
  } split_t;

  // Four frame bytes, entry 0 goes out first.
  typedef logic [3:0][7:0] frame_t;

  // Handshake between the frame builder and the byte serializer.
  typedef struct packed {
    logic   load;
    frame_t bytes;
  } frame_req_t;

  // Blank for digits above the hex range.
  function automatic logic [7:0] seg_of(input logic [6:0] d);
    logic [7:0] seg;
    if (d < 7'd16) begin
      seg = SEG_TABLE[d[3:0]];
    end else begin
      seg = 8'h00;
    end
    return seg;
  endfunction

endpackage
`default_nettype wire

// ----- design/ssd_split.sv -----
// Input register and thousands split stage.
`default_nettype none
module ssd_split import ssd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [15:0] in_value,
  input  wire logic        b_take,
  output logic             b_vld,
  output split_t           b_item
);

  logic        a_vld_r;
  mode_t       a_mode_r;
  logic [15:0] a_value_r;
  logic        b_vld_r;
  split_t      b_item_r;
  logic        b_ready;

  logic [26:0] q_prod;
  logic [6:0]  d3;
  logic [15:0] r_full;
  split_t      b_item_nxt;

  assign b_ready  = !b_vld_r || b_take;
  assign in_ready = !a_vld_r || b_ready;

  // v / 1000 == (v >> 3) / 125, reciprocal 8389 / 2^20 is exact for 13-bit values
  always_comb begin
    q_prod              = 27'(a_value_r[15:3]) * 27'd8389;
    d3                  = q_prod[26:20];
    r_full              = a_value_r - 16'(d3) * 16'd1000;
    b_item_nxt.mode     = a_mode_r;
    b_item_nxt.d3       = d3;
    b_item_nxt.rem      = r_full[9:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        a_vld_r <= in_valid;
      end
      if (b_ready) begin
        b_vld_r <= a_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_mode_r  <= mode_t'(in_mode);
      a_value_r <= in_value;
    end
    if (a_vld_r && b_ready) begin
      b_item_r <= b_item_nxt;
    end
  end

  assign b_vld  = b_vld_r;
  assign b_item = b_item_r;

endmodule
`default_nettype wire

// ----- design/ssd_disp.sv -----
// Digit store, scan index and frame builder.
`default_nettype none
module ssd_disp import ssd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       b_vld,
  input  wire split_t     b_item,
  input  wire logic       frame_free,
  output logic            b_take,
  output frame_req_t      frame_req
);

  logic [6:0]  dig_r [4];
  logic [1:0]  idx_r;
  logic [1:0]  idx_nxt;

  logic [15:0] p2;
  logic [3:0]  d2;
  logic [9:0]  r2_full;
  logic [6:0]  r2;
  logic [14:0] p1;
  logic [3:0]  d1;
  logic [6:0]  d0_full;
  logic [3:0]  d0;
  logic [6:0]  dig_new [4];

  logic        needs_frame;
  logic [2:0]  idx_inc;
  logic [7:0]  sel;

  // Remaining digits of a value below 1000
  always_comb begin
    p2         = 16'(b_item.rem) * 16'd41;
    d2         = p2[15:12];
    r2_full    = b_item.rem - 10'(d2) * 10'd100;
    r2         = r2_full[6:0];
    p1         = 15'(r2) * 15'd205;
    d1         = p1[14:11];
    d0_full    = r2 - 7'(d1) * 7'd10;
    d0         = d0_full[3:0];
    dig_new[0] = {3'b000, d0};
    dig_new[1] = {3'b000, d1};
    dig_new[2] = {3'b000, d2};
    dig_new[3] = b_item.d3;
  end

  always_comb begin
    needs_frame = (b_item.mode == MODE_INIT) || (b_item.mode == MODE_SCAN);
    b_take      = b_vld && (!needs_frame || frame_free);
    idx_inc     = {1'b0, idx_r} + 3'd1;
    idx_nxt     = (32'(idx_inc) >= DIGITS) ? 2'd0 : idx_inc[1:0];
    sel         = 8'd1 << idx_r;
    frame_req.load = b_vld && needs_frame && frame_free;
    if (b_item.mode == MODE_SCAN) begin
      frame_req.bytes = {seg_of(dig_r[idx_r]), sel, REG_LATA, OP_WRITE};
    end else begin
      frame_req.bytes = {DIR_B_VAL, DIR_A_VAL, REG_DIRA, OP_WRITE};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
      for (int i = 0; i < 4; i++) begin
        dig_r[i] <= 7'd0;
      end
    end else if (b_take) begin
      if (b_item.mode == MODE_LOAD) begin
        for (int i = 0; i < 4; i++) begin
          if (i < DIGITS) begin
            dig_r[i] <= dig_new[i];
          end
        end
      end
      if (b_item.mode == MODE_SCAN) begin
        idx_r <= idx_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/ssd_ser.sv -----
// Frame register that sends its four bytes one per handshake.
`default_nettype none
module ssd_ser import ssd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire frame_req_t  frame_req,
  output logic             frame_free,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_spi_byte,
  output logic             out_last_byte
);

  logic       frm_vld_r;
  logic [1:0] cnt_r;
  frame_t     bytes_r;
  logic       last;
  logic       done;

  assign last       = (cnt_r == 2'd3);
  assign done       = frm_vld_r && out_ready && last;
  assign frame_free = !frm_vld_r || done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frm_vld_r <= 1'b0;
      cnt_r     <= 2'd0;
    end else if (frame_req.load) begin
      frm_vld_r <= 1'b1;
      cnt_r     <= 2'd0;
    end else if (frm_vld_r && out_ready) begin
      cnt_r <= cnt_r + 2'd1;
      if (last) begin
        frm_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_req.load) begin
      bytes_r <= frame_req.bytes;
    end
  end

  assign out_valid     = frm_vld_r;
  assign out_spi_byte  = bytes_r[cnt_r];
  assign out_last_byte = last;

endmodule
`default_nettype wire

// ----- design/seven_segment_scan_driver_top.sv -----
// An item passes the input and split registers before its frame loads into the
// serializer. Load items go one per cycle unless a frame item waits ahead; init and
// scan items each send a 4-byte frame, one byte per cycle while out_ready is high,
// the next frame loading as the last byte goes. Reset (rst_n low, synchronous): digit
// store to zeros, scan index to 0, all pipeline and frame valids cleared.
`default_nettype none
module seven_segment_scan_driver_top import ssd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [15:0] in_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_spi_byte,
  output logic             out_last_byte
);

  logic       b_vld;
  split_t     b_item;
  logic       b_take;
  logic       frame_free;
  frame_req_t frame_req;

  ssd_split u_split (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_mode  (in_mode),
    .in_value (in_value),
    .b_take   (b_take),
    .b_vld    (b_vld),
    .b_item   (b_item)
  );

  ssd_disp u_disp (
    .clk        (clk),
    .rst_n      (rst_n),
    .b_vld      (b_vld),
    .b_item     (b_item),
    .frame_free (frame_free),
    .b_take     (b_take),
    .frame_req  (frame_req)
  );

  ssd_ser u_ser (
    .clk           (clk),
    .rst_n         (rst_n),
    .frame_req     (frame_req),
    .frame_free    (frame_free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_spi_byte  (out_spi_byte),
    .out_last_byte (out_last_byte)
  );

  // A new frame never overwrites bytes still waiting
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    frame_req.load |-> frame_free)
    else $error("frame loaded while serializer busy");

  // Every frame opens with the write opcode
  a_first_op: assert property (@(posedge clk) disable iff (!rst_n)
    frame_req.load |=> (out_valid && out_spi_byte == OP_WRITE && !out_last_byte))
    else $error("frame does not start with write opcode");

  // Output goes idle after the last byte unless another frame is loaded
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_byte && !frame_req.load) |=> !out_valid)
    else $error("output stays valid after last byte");

endmodule
`default_nettype wire

// ----- verif/tb_seven_segment_scan_driver_top.sv -----
// Self-checking testbench for the seven-segment scan driver frame output.
`timescale 1ns / 1ps
module tb_seven_segment_scan_driver_top;
  import ssd_pkg::*;

  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } frame_byte_t;

  // Tracks digit store and scan position, queues the frame bytes each item causes.
  class frame_scoreboard;
    logic [6:0]  digits [4];
    logic [1:0]  scan_idx;
    frame_byte_t frame_bytes_q [$];
    int          errors;

    function new();
      foreach (digits[i]) digits[i] = 7'd0;
      scan_idx = 2'd0;
      errors   = 0;
    endfunction

    function void push_frame(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, logic [7:0] b3);
      frame_bytes_q.push_back('{1'b0, b0});
      frame_bytes_q.push_back('{1'b0, b1});
      frame_bytes_q.push_back('{1'b0, b2});
      frame_bytes_q.push_back('{1'b1, b3});
    endfunction

    function void note_item(logic [1:0] m, logic [15:0] v);
      int unsigned rest;
      int unsigned nxt;
      logic [6:0]  d [4];
      logic [6:0]  cur;
      logic [7:0]  seg;
      case (mode_t'(m))
        MODE_INIT: push_frame(OP_WRITE, REG_DIRA, DIR_A_VAL, DIR_B_VAL);
        MODE_LOAD: begin
          rest = v;
          d[3] = 7'(rest / 1000);
          rest = rest % 1000;
          d[2] = 7'(rest / 100);
          rest = rest % 100;
          d[1] = 7'(rest / 10);
          d[0] = 7'(rest % 10);
          for (int i = 0; i < DIGITS && i < 4; i++) digits[i] = d[i];
        end
        MODE_SCAN: begin
          cur = digits[scan_idx];
          // blank anything past the hex range
          seg = (cur < 7'd16) ? SEG_TABLE[cur[3:0]] : 8'h00;
          push_frame(OP_WRITE, REG_LATA, 8'd1 << scan_idx, seg);
          nxt = scan_idx + 1;
          scan_idx = (nxt >= DIGITS) ? 2'd0 : 2'(nxt);
        end
        default: ;
      endcase
    endfunction

    function void check_byte(logic [7:0] data, logic last);
      frame_byte_t want;
      if (frame_bytes_q.size() == 0) begin
        $display("%0t: unexpected byte spi_byte=%h last_byte=%b", $time, data, last);
        errors++;
        return;
      end
      want = frame_bytes_q.pop_front();
      if (data !== want.data) begin
        $display("%0t: spi_byte expected %h actual %h", $time, want.data, data);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last_byte expected %b actual %b", $time, want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return frame_bytes_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = MODE_INIT;
  logic [15:0] in_value = 16'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_spi_byte;
  logic        out_last_byte;

  frame_scoreboard sb = new();
  int burst_left = 0;

  int          ready_left = 0;
  logic [7:0]  ready_pat = 8'hFF;
  logic [2:0]  ready_pos = 3'd0;

  seven_segment_scan_driver_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_spi_byte (out_spi_byte),
    .out_last_byte(out_last_byte)
  );

  always #5 clk = ~clk;

  // Watch both handshakes on the values present before the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_item(in_mode, in_value);
      if (out_valid && out_ready) sb.check_byte(out_spi_byte, out_last_byte);
    end
  end

  // Receiver stalls on a rotating 8-bit pattern that is redrawn whenever its countdown expires.
  always @(posedge clk) begin
    if (ready_left <= 0) begin
      ready_left = $urandom_range(20, 80);
      ready_pat  = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
    end
    ready_left--;
    ready_pos = ready_pos + 3'd1;
    out_ready <= ready_pat[ready_pos];
  end

  // Call right after a rising edge; returns right after the edge that accepts the item.
  task automatic send_item(input logic [1:0] m, input logic [15:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_mode  <= m;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_scans(input int n);
    repeat (n) send_item(MODE_SCAN, 16'($urandom));
  endtask

  initial begin
    int          sent;
    int unsigned pick;
    logic [15:0] v;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset digits, extremes, hex thousands, blank thousands, unused mode
    send_item(MODE_INIT, 16'hFFFF);
    send_scans(1);
    send_item(MODE_LOAD, 16'd65535);
    send_scans(4);
    send_item(MODE_LOAD, 16'd10000);
    send_scans(3);
    send_item(MODE_LOAD, 16'd11111);
    send_scans(4);
    send_item(MODE_LOAD, 16'd15999);
    send_scans(4);
    send_item(MODE_LOAD, 16'd16000);
    send_item(MODE_NONE, 16'hAAAA);
    send_item(MODE_NONE, 16'h5555);
    send_scans(4);
    send_item(MODE_INIT, 16'h0000);
    send_item(MODE_LOAD, 16'd0);
    send_scans(1);

    // random: mostly scans mixed with loads, with some init and unused-mode noise
    sent = 0;
    while (sent < 90) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        send_item(MODE_NONE, 16'($urandom));
      end else begin
        sent++;
        if (pick < 15) begin
          send_item(MODE_INIT, 16'($urandom));
        end else if (pick < 45) begin
          case ($urandom_range(0, 5))
            0, 1: v = 16'($urandom_range(10000, 15999));
            2:    v = 16'($urandom_range(16000, 65535));
            3:    v = 16'($urandom_range(0, 999));
            default: v = 16'($urandom);
          endcase
          send_item(MODE_LOAD, v);
        end else begin
          send_item(MODE_SCAN, 16'($urandom));
        end
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    // drain: let any stray byte surface
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
